// File: rtl/sitod_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitod_pkg: shared types and constants
// Widths, digit counts and the record passed from the front to the back.
// ---------------------------------------------------------------------------
package sitod_pkg;

  // Integer width of the converted value (8..64).
  localparam int WIDTH = 32;

  // Decimal digits of the largest magnitude, 2**(WIDTH-1).
  localparam int NDIG = ((WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int DIG_IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  // Magnitude is consumed four bits per cycle.
  localparam int STEPS = (WIDTH + 3) / 4;
  localparam int MAGW = STEPS * 4;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);

  // Decoupling queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One converted number: sign, index of its leading digit, BCD digits.
  typedef struct packed {
    logic                 neg;
    logic [DIG_IDX_W-1:0] top;
    logic [BCD_W-1:0]     bcd;
  } sitod_rec_t;

  // Digit 0..9 to its ASCII code.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

endpackage
`default_nettype wire

// File: rtl/sitod_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitod_if: stream channels
// Input channel carries one integer, output channel one character.
// ---------------------------------------------------------------------------
interface sitod_in_if import sitod_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitod_out_if import sitod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink (input valid, input character, input is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/sitod_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitod_front: sign split and binary to BCD conversion
// Takes one integer, converts its magnitude 4 bits per cycle (shift-add-3).
// ---------------------------------------------------------------------------
module sitod_front import sitod_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  sitod_in_if.sink   in_ch,
  output logic       rec_valid,
  input  wire        rec_ready,
  output sitod_rec_t rec_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [MAGW-1:0]      mag_r;
  logic [BCD_W-1:0]     bcd_r;
  logic                 neg_r;
  logic [WIDTH-1:0]     mag_abs;
  logic [DIG_IDX_W-1:0] top_idx;

  // Four dependent shift-add-3 steps.
  function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] b,
                                               input logic [3:0] bits);
    logic [BCD_W-1:0] t;
    t = b;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < NDIG; d++) begin
        if (t[d*4 +: 4] >= 4'd5) t[d*4 +: 4] = t[d*4 +: 4] + 4'd3;
      end
      t = {t[BCD_W-2:0], bits[s]};
    end
    return t;
  endfunction

  always_comb begin
    mag_abs = $unsigned(in_ch.value);
    if (in_ch.value[WIDTH-1]) mag_abs = ~mag_abs + WIDTH'(1);
  end

  // Leading digit index; zero keeps index 0 so a lone '0' goes out.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) top_idx = DIG_IDX_W'(d);
    end
  end

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign rec_valid     = (state_r == ST_PUSH);
  assign rec_data.neg  = neg_r;
  assign rec_data.top  = top_idx;
  assign rec_data.bcd  = bcd_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_r == '0) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (rec_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) cnt_r <= CNT_W'(STEPS - 1);
      else if (state_r == ST_CONV) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      neg_r <= in_ch.value[WIDTH-1];
      mag_r <= MAGW'(mag_abs);
      bcd_r <= '0;
    end else if (state_r == ST_CONV) begin
      bcd_r <= dabble4(bcd_r, mag_r[MAGW-1 -: 4]);
      mag_r <= mag_r << 4;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sitod_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitod_fifo: short record queue
// Flop-based FIFO that decouples conversion from character output.
// ---------------------------------------------------------------------------
module sitod_fifo import sitod_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push_valid,
  output logic       push_ready,
  input  sitod_rec_t push_data,
  output logic       pop_valid,
  input  wire        pop_ready,
  output sitod_rec_t pop_data
);

  sitod_rec_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) cnt_r <= cnt_r + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// File: rtl/sitod_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitod_back: character sequencer
// Walks one record: optional '-', then digits from the leading one down.
// ---------------------------------------------------------------------------
module sitod_back import sitod_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         rec_valid,
  output logic        rec_ready,
  input  sitod_rec_t  rec_data,
  sitod_out_if.source out_ch
);

  logic                 cur_valid_r;
  logic                 neg_pend_r;
  logic [DIG_IDX_W-1:0] idx_r;
  logic [BCD_W-1:0]     bcd_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;
  logic                 load_out, emit, finish, pop;
  logic [3:0]           cur_digit;

  assign load_out  = !out_valid_r || out_ch.ready;
  assign emit      = cur_valid_r && load_out;
  assign cur_digit = bcd_r[{idx_r, 2'b00} +: 4];
  assign finish    = emit && !neg_pend_r && (idx_r == '0);
  assign rec_ready = !cur_valid_r || finish;
  assign pop       = rec_valid && rec_ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.is_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      neg_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (pop) begin
        cur_valid_r <= 1'b1;
        neg_pend_r  <= rec_data.neg;
      end else begin
        if (finish) cur_valid_r <= 1'b0;
        if (emit) neg_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (neg_pend_r) begin
        out_char_r <= CHAR_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= digit_char(cur_digit);
        out_last_r <= (idx_r == '0);
      end
    end
    if (pop) begin
      idx_r <= rec_data.top;
      bcd_r <= rec_data.bcd;
    end else if (emit && !neg_pend_r && idx_r != '0) begin
      idx_r <= idx_r - DIG_IDX_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: integer to decimal ASCII text
// Converts a signed integer into its decimal characters, MSB digit first.
// ---------------------------------------------------------------------------
// Usage:
//  in_ch  : one signed WIDTH-bit integer per transaction (valid/ready).
//  out_ch : one ASCII character per transaction; '-' first for negative
//           values, then digits with no leading zeros; is_last marks the
//           final character. Zero gives a single '0'. Most negative value
//           converts exactly.
//  Front: splits sign, runs a shift-add-3 BCD converter at 4 magnitude
//         bits per cycle (STEPS = 8 steps at WIDTH 32).
//  Queue: two records, so the front converts the next number while the
//         back is still emitting characters.
//  Back : emits one character per cycle from a registered output
//         stage, while the receiver does not stall it.
//  Input: a new integer is taken only once the front is idle again,
//         after its record entered the queue. A number gives 1..11
//         characters at WIDTH 32.
//  Reset (rst_n low, synchronous): queue emptied, pending text dropped,
//         out_ch.valid low on the next cycle.
//  Receiver stall: the output character holds; the queue fills, then
//         in_ch.ready drops until space frees.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit import sitod_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  sitod_in_if.sink    in_ch,
  sitod_out_if.source out_ch
);

  // Front to queue
  logic       f_valid, f_ready;
  sitod_rec_t f_data;
  // Queue to back
  logic       b_valid, b_ready;
  sitod_rec_t b_data;

  sitod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec_data  (f_data)
  );

  sitod_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  sitod_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (b_valid),
    .rec_ready (b_ready),
    .rec_data  (b_data),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// File: rtl/sitod_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sitod_checker: output channel checks
// Watches the result port of the converter over time.
// ---------------------------------------------------------------------------
module sitod_checker import sitod_pkg::*; (
  input wire              clk,
  input wire              rst_n,
  input wire              out_valid,
  input wire              out_ready,
  input wire [CHAR_W-1:0] out_character,
  input wire              out_is_last
);

  // Stalled transaction keeps valid
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // Stalled transaction keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_character) && $stable(out_is_last))
    else $error("out payload changed while stalled");

  // Only '-' or a decimal digit
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  ((out_character >= CHAR_ZERO) &&
                   (out_character <= CHAR_ZERO + CHAR_W'(9))))
    else $error("illegal character");

  // The sign never ends a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == CHAR_MINUS) |-> !out_is_last)
    else $error("minus flagged as last");

  // Reset clears the output stage
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sitod_checker u_sitod_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_is_last   (out_ch.is_last)
);
`default_nettype wire

// File: test/signed_int_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb: self-checking bench for the itoa unit
// Feeds signed integers through the input channel and compares every ASCII
// character that comes out against a local decimal-text predictor. Covers
// digit-count boundaries, both extremes, random magnitudes of every length,
// bursty input, output stalls and a long output hold-off.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;
  import sitod_pkg::*;

  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 16;   // idle wait after the last expected character
  localparam int RANDOM_COUNT = 270;

  // One expected character of the decimal text.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sitod_in_if  in_ch ();
  sitod_out_if out_ch ();

  signed_int_to_decimal_ascii_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Expected text of every accepted number, character by character.
  text_char_t expected_text_q[$];

  int mismatch_count;
  int numbers_sent;
  int negatives_sent;
  int chars_checked;
  int longest_text;

  // Hold-off requests: the test side bumps hold_requests, the receiver
  // process notices and runs the hold itself.
  int hold_requests;

  // -------------------------------------------------------------------------
  // Decimal text predictor. The magnitude is held at WIDTH+1 bits so the
  // most negative value negates without overflow.
  // -------------------------------------------------------------------------
  function automatic void predict_decimal_text(input logic signed [WIDTH-1:0] v);
    logic [WIDTH:0] magnitude;
    logic [3:0]     digit;
    logic [3:0]     digits[$];
    logic           negative;
    text_char_t     ch;
    negative = v[WIDTH-1];
    magnitude = negative ? -{1'b1, v} : {1'b0, v};
    do begin
      digit = 4'(magnitude % 10);
      digits.push_front(digit);
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      expected_text_q.push_back(ch);
      negatives_sent++;
    end
    foreach (digits[i]) begin
      ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
      ch.last = (i == digits.size() - 1);
      expected_text_q.push_back(ch);
    end
    if (digits.size() + int'(negative) > longest_text)
      longest_text = digits.size() + int'(negative);
  endfunction

  // -------------------------------------------------------------------------
  // Input side: drive at the falling edge, take the transaction at the
  // rising edge where valid and ready are both high.
  // -------------------------------------------------------------------------
  task automatic send_number(input logic signed [WIDTH-1:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    predict_decimal_text(v);
    numbers_sent++;
  endtask

  // Drop valid for a pause; the data lines carry noise meanwhile.
  task automatic pause_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.value <= WIDTH'({$urandom, $urandom});
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending and let every outstanding character come out, then give
  // the unit time to show any stray transaction.
  task automatic wait_for_drain();
    pause_input(1);
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random value with a random number of significant bits, so every text
  // length shows up; some picks sit right at the extremes.
  function automatic logic signed [WIDTH-1:0] random_number();
    logic signed [WIDTH-1:0] v;
    logic signed [WIDTH-1:0] edge_value;
    int unsigned             pick;
    pick = $urandom_range(0, 9);
    v = WIDTH'({$urandom, $urandom});
    if (pick >= 4 && pick < 8) begin
      v = v >>> $urandom_range(1, WIDTH - 1);
    end else if (pick >= 8) begin
      edge_value = $urandom_range(0, 1) ? {1'b0, {(WIDTH-1){1'b1}}} : {1'b1, {(WIDTH-1){1'b0}}};
      v = edge_value + WIDTH'($signed($urandom_range(0, 6)) - 3);
    end
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // Output side: ready follows a randomly picked pattern (always ready,
  // coin toss, one cycle in four), overridden by a long hold-off
  // whenever one is requested.
  // -------------------------------------------------------------------------
  initial begin : receiver
    int holds_served;
    int hold_left;
    int pattern;
    int cycle;
    holds_served = 0;
    hold_left = 0;
    pattern = 0;
    cycle = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (cycle % 48 == 0) pattern = $urandom_range(0, 2);
      cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (pattern)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (cycle % 4 == 0);
        endcase
      end
    end
  end

  // Every output transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_text_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected character %0d last=%0d, nothing pending",
                   $realtime, out_ch.character, out_ch.is_last);
      end else begin
        want = expected_text_q.pop_front();
        chars_checked++;
        if (out_ch.character !== want.code || out_ch.is_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: character exp %0d last=%0d, got %0d last=%0d",
                     $realtime, want.code, want.last, out_ch.character, out_ch.is_last);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Zero, +-1, both extremes, and each digit-count boundary: 10**k and
  // -(10**k - 1), so every text length appears with and without a sign.
  task automatic test_directed_extremes();
    longint max_value;
    longint p;
    max_value = (longint'(1) <<< (WIDTH - 1)) - 1;
    send_number('0);
    send_number(WIDTH'(1));
    send_number('1);
    send_number({1'b0, {(WIDTH-1){1'b1}}});
    send_number({1'b1, {(WIDTH-1){1'b0}}});
    send_number({1'b1, {(WIDTH-2){1'b0}}, 1'b1});
    p = 10;
    while (p <= max_value) begin
      send_number(WIDTH'(p));
      send_number(WIDTH'(-(p - 1)));
      if (p > max_value / 10) break;
      p = p * 10;
    end
    wait_for_drain();
  endtask

  // Random numbers in bursts; most bursts are short with gaps, some are
  // long with no gap at all.
  task automatic test_random_stream();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_COUNT) begin
      burst = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
      if (burst > RANDOM_COUNT - sent) burst = RANDOM_COUNT - sent;
      repeat (burst) begin
        send_number(random_number());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 15));
    end
    wait_for_drain();
  endtask

  // Hold the output off for a long stretch while numbers keep coming, so
  // the internal queue fills and the input channel has to stall.
  task automatic test_output_backpressure();
    hold_requests++;
    repeat (16) send_number(random_number());
    wait_for_drain();
  endtask

  // Short batches, each fully drained before the next starts.
  task automatic test_drain_between_batches();
    repeat (3) begin
      repeat ($urandom_range(1, 4)) send_number(random_number());
      wait_for_drain();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    mismatch_count = 0;
    numbers_sent = 0;
    negatives_sent = 0;
    chars_checked = 0;
    longest_text = 0;
    hold_requests = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_output_backpressure();
    test_random_stream();
    test_drain_between_batches();

    $display("Converted %0d numbers (%0d negative) into %0d characters, longest text %0d.",
             numbers_sent, negatives_sent, chars_checked, longest_text);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d characters outstanding", expected_text_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sitod_pkg.sv
rtl/sitod_if.sv
rtl/sitod_front.sv
rtl/sitod_fifo.sv
rtl/sitod_back.sv
rtl/signed_int_to_decimal_ascii_unit.sv
rtl/sitod_checker.sv
test/signed_int_to_decimal_ascii_unit_tb.sv
